@@ rtl/core/hle_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hle_pkg;

	// field widths
	localparam int S_W    = 32;  // squared residual, Q16.16
	localparam int CFG_W  = 32;  // scale a, threshold b, Q16.16
	localparam int VAL_W  = 48;  // loss value, Q32.16
	localparam int D1_W   = 32;  // first derivative, Q16.16
	localparam int D2_W   = 48;  // second derivative, Q16.32

	// square root of s * 2^16
	localparam int RAD_W    = 48;
	localparam int ROOT_W   = 24;
	localparam int SQ_REM_W = 26;
	localparam int SQ_STEPS = 3;
	localparam int N_SQ     = ROOT_W / SQ_STEPS;

	// a * 2^16 / r
	localparam int D1_BITS_W = 32;
	localparam int D1_STEPS  = 4;
	localparam int N_D1      = D1_W / D1_STEPS;

	// d1 * 2^31 / s
	localparam int D2_Q_W   = 48;
	localparam int D2_STEPS = 4;
	localparam int N_D2     = D2_Q_W / D2_STEPS;

	localparam int PROD_W = CFG_W + ROOT_W;

	localparam logic [D1_W-1:0] ONE_Q16     = D1_W'(65536);
	localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(65536);
	localparam logic [D2_W-1:0] SAT_NEG_MAG = {1'b1, {(D2_W-1){1'b0}}};

	typedef enum logic [0:0] {
		REG_SCALE_A     = 1'b0,
		REG_THRESHOLD_B = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [VAL_W-1:0] loss_value;
		logic [D1_W-1:0]  first_deriv;
		logic [D2_W-1:0]  second_deriv;
		logic             is_outlier;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/hle_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface hle_in_if;
	import hle_pkg::*;
	logic             valid;
	logic             ready;
	logic [S_W-1:0]   squared_residual;
	modport source(output valid, output squared_residual, input ready);
	modport sink(input valid, input squared_residual, output ready);
endinterface

interface hle_out_if;
	import hle_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] loss_value;
	logic [D1_W-1:0]         first_deriv;
	logic signed [D2_W-1:0]  second_deriv;
	logic                    is_outlier;
	modport source(output valid, output loss_value, output first_deriv,
		output second_deriv, output is_outlier, input ready);
	modport sink(input valid, input loss_value, input first_deriv,
		input second_deriv, input is_outlier, output ready);
endinterface

`default_nettype wire

@@ rtl/core/huber_loss_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Payload                                                  Beat when
// residual   in   squared_residual                                         valid & ready
// result     out  loss_value, first_deriv, second_deriv, is_outlier        valid & ready
// wr_*       in   wr_index, wr_data                                        wr_en
//
// One beat in per cycle while residual.ready is high, that is while the output
// buffer is not full. The digit pipelines are square root (3 digits per
// stage, 8 stages), a*2^16/r (4 bits per stage, 8 stages), d1*2^31/s
// (4 bits per stage, 12 stages), plus a multiply and a clamp stage.
// Reset clears the stage valid bits and the output buffer and sets a, b to 1.0.
// A two-entry output buffer holds results while result.ready is low; the
// whole pipeline halts only when both entries are full.
module huber_loss_eval (
	input  wire                        clk,
	input  wire                        arst_n,
	hle_in_if.sink                     residual,
	hle_out_if.source                  result,
	input  wire                        wr_en,
	input  wire [0:0]                  wr_index,
	input  wire [hle_pkg::CFG_W-1:0]   wr_data
);
	import hle_pkg::*;

	// configuration
	logic [CFG_W-1:0] scale_a_q;
	logic [CFG_W-1:0] threshold_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_a_q     <= CFG_RESET;
			threshold_b_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_SCALE_A:     scale_a_q     <= wr_data;
				REG_THRESHOLD_B: threshold_b_q <= wr_data;
				default: ;
			endcase
		end
	end

	// global advance: halts only when the output buffer is full
	logic en;
	logic skid_v_q;
	assign en = !skid_v_q;
	assign residual.ready = en;

	// ---- square root stages: r = floor(sqrt(s * 2^16)) ----
	localparam int SQ_SIDE_W = S_W + 1;

	logic                sq_v    [0:N_SQ];
	logic [RAD_W-1:0]    sq_rad  [0:N_SQ];
	logic [SQ_REM_W-1:0] sq_rem  [0:N_SQ];
	logic [ROOT_W-1:0]   sq_root [0:N_SQ];
	logic [SQ_SIDE_W-1:0] sq_side [0:N_SQ];

	assign sq_v[0]    = residual.valid;
	assign sq_rad[0]  = {residual.squared_residual, 16'b0};
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	// outlier flag rides in the top bit; s == b is an inlier
	assign sq_side[0] = {(residual.squared_residual > threshold_b_q),
		residual.squared_residual};

	for (genvar g = 0; g < N_SQ; g++) begin : g_sq
		hle_sqrt_stage #(.STEPS(SQ_STEPS), .SIDE_W(SQ_SIDE_W)) u_sq (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(sq_v[g]), .rad_in(sq_rad[g]), .rem_in(sq_rem[g]),
			.root_in(sq_root[g]), .side_in(sq_side[g]),
			.v_out(sq_v[g+1]), .rad_out(sq_rad[g+1]), .rem_out(sq_rem[g+1]),
			.root_out(sq_root[g+1]), .side_out(sq_side[g+1])
		);
	end

	// ---- stage 9: a*r product and first-quotient overflow test ----
	logic              v_s9;
	logic [PROD_W-1:0] prod_s9;
	logic [ROOT_W-1:0] root_s9;
	logic              ovf1_s9;
	logic [S_W-1:0]    s_s9;
	logic              outl_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= sq_v[N_SQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s9 <= PROD_W'(scale_a_q) * PROD_W'(sq_root[N_SQ]);
			root_s9 <= sq_root[N_SQ];
			// a*2^16/r >= 2^32  <=>  a >= r*2^16
			ovf1_s9 <= ({8'b0, scale_a_q} >= {sq_root[N_SQ], 16'b0});
			s_s9    <= sq_side[N_SQ][S_W-1:0];
			outl_s9 <= sq_side[N_SQ][S_W];
		end
	end

	// ---- first derivative division: a*2^16 / r ----
	localparam int D1_SIDE_W = 1 + S_W + PROD_W + 1;

	logic                 d1_v    [0:N_D1];
	logic [D1_BITS_W-1:0] d1_bits [0:N_D1];
	logic [ROOT_W-1:0]    d1_rem  [0:N_D1];
	logic [D1_W-1:0]      d1_quo  [0:N_D1];
	logic [ROOT_W-1:0]    d1_dvs  [0:N_D1];
	logic [D1_SIDE_W-1:0] d1_side [0:N_D1];

	assign d1_v[0]    = v_s9;
	assign d1_bits[0] = {scale_a_q[15:0], 16'b0};
	assign d1_rem[0]  = ROOT_W'(scale_a_q[CFG_W-1:16]);
	assign d1_quo[0]  = '0;
	assign d1_dvs[0]  = root_s9;
	assign d1_side[0] = {outl_s9, s_s9, prod_s9, ovf1_s9};

	for (genvar g = 0; g < N_D1; g++) begin : g_d1
		hle_div_stage #(
			.DIV_W(ROOT_W), .BITS_W(D1_BITS_W), .Q_W(D1_W),
			.STEPS(D1_STEPS), .SIDE_W(D1_SIDE_W)
		) u_div (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(d1_v[g]), .bits_in(d1_bits[g]), .rem_in(d1_rem[g]),
			.quo_in(d1_quo[g]), .dvs_in(d1_dvs[g]), .side_in(d1_side[g]),
			.v_out(d1_v[g+1]), .bits_out(d1_bits[g+1]), .rem_out(d1_rem[g+1]),
			.quo_out(d1_quo[g+1]), .dvs_out(d1_dvs[g+1]), .side_out(d1_side[g+1])
		);
	end

	// ---- stage 18: clamp d1, finish loss value, second overflow test ----
	logic              d1_outl;
	logic [S_W-1:0]    d1_s;
	logic [PROD_W-1:0] d1_prod;
	logic              d1_ovf;
	logic [D1_W-1:0]   d1_clamped;

	assign {d1_outl, d1_s, d1_prod, d1_ovf} = d1_side[N_D1];

	always_comb begin
		if (d1_ovf) begin
			d1_clamped = '1;
		end else if (d1_quo[N_D1] == '0) begin
			d1_clamped = D1_W'(1);
		end else begin
			d1_clamped = d1_quo[N_D1];
		end
	end

	logic             v_s18;
	logic [D1_W-1:0]  d1_s18;
	logic [VAL_W-1:0] val_s18;
	logic             ovf2_s18;
	logic [S_W-1:0]   s_s18;
	logic             outl_s18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s18 <= 1'b0;
		end else if (en) begin
			v_s18 <= d1_v[N_D1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s18   <= d1_clamped;
			// (2*a*r) >> 16 - b, modulo 2^48
			val_s18  <= VAL_W'(d1_prod[PROD_W-1:15]) - VAL_W'(threshold_b_q);
			// d1*2^31/s >= 2^47  <=>  d1 >= s*2^16
			ovf2_s18 <= ({16'b0, d1_clamped} >= {d1_s, 16'b0});
			s_s18    <= d1_s;
			outl_s18 <= d1_outl;
		end
	end

	// ---- second derivative division: d1*2^31 / s ----
	localparam int D2_SIDE_W = 1 + VAL_W + D1_W + 1;

	logic                 d2_v    [0:N_D2];
	logic [D2_Q_W-1:0]    d2_bits [0:N_D2];
	logic [S_W-1:0]       d2_rem  [0:N_D2];
	logic [D2_Q_W-1:0]    d2_quo  [0:N_D2];
	logic [S_W-1:0]       d2_dvs  [0:N_D2];
	logic [D2_SIDE_W-1:0] d2_side [0:N_D2];

	assign d2_v[0]    = v_s18;
	assign d2_bits[0] = {d1_s18[16:0], 31'b0};
	assign d2_rem[0]  = S_W'(d1_s18[D1_W-1:17]);
	assign d2_quo[0]  = '0;
	assign d2_dvs[0]  = s_s18;
	assign d2_side[0] = {outl_s18, val_s18, d1_s18, ovf2_s18};

	for (genvar g = 0; g < N_D2; g++) begin : g_d2
		hle_div_stage #(
			.DIV_W(S_W), .BITS_W(D2_Q_W), .Q_W(D2_Q_W),
			.STEPS(D2_STEPS), .SIDE_W(D2_SIDE_W)
		) u_div (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(d2_v[g]), .bits_in(d2_bits[g]), .rem_in(d2_rem[g]),
			.quo_in(d2_quo[g]), .dvs_in(d2_dvs[g]), .side_in(d2_side[g]),
			.v_out(d2_v[g+1]), .bits_out(d2_bits[g+1]), .rem_out(d2_rem[g+1]),
			.quo_out(d2_quo[g+1]), .dvs_out(d2_dvs[g+1]), .side_out(d2_side[g+1])
		);
	end

	// ---- result assembly ----
	logic             f_outl;
	logic [VAL_W-1:0] f_val;
	logic [D1_W-1:0]  f_d1;
	logic             f_ovf;
	logic [D2_W-1:0]  f_mag;
	result_t          push_d;
	logic             push;

	assign {f_outl, f_val, f_d1, f_ovf} = d2_side[N_D2];
	assign f_mag = f_ovf ? SAT_NEG_MAG : d2_quo[N_D2];

	always_comb begin
		if (f_outl) begin
			push_d.loss_value   = f_val;
			push_d.first_deriv  = f_d1;
			push_d.second_deriv = D2_W'(0) - f_mag;
			push_d.is_outlier   = 1'b1;
		end else begin
			// inlier: s passes through; it rides along as the second divisor
			push_d.loss_value   = VAL_W'(d2_dvs[N_D2]);
			push_d.first_deriv  = ONE_Q16;
			push_d.second_deriv = '0;
			push_d.is_outlier   = 1'b0;
		end
	end

	assign push = en && d2_v[N_D2];

	// ---- two-entry output buffer ----
	result_t head_q;
	result_t skid_q;
	logic    head_v_q;
	logic    pop;

	assign pop = head_v_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (head_v_q && !pop) begin
			if (push) begin
				skid_v_q <= 1'b1;
			end
		end else begin
			head_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				head_q <= skid_q;
			end
		end else if (head_v_q && !pop) begin
			if (push) begin
				skid_q <= push_d;
			end
		end else if (push) begin
			head_q <= push_d;
		end
	end

	assign result.valid        = head_v_q;
	assign result.loss_value   = head_q.loss_value;
	assign result.first_deriv  = head_q.first_deriv;
	assign result.second_deriv = head_q.second_deriv;
	assign result.is_outlier   = head_q.is_outlier;

endmodule

`default_nettype wire

@@ rtl/core/hle_sqrt_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A few digits of a restoring integer square root, then one register stage.
module hle_sqrt_stage #(
	parameter int STEPS  = 3,
	parameter int SIDE_W = 33
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          v_in,
	input  wire [hle_pkg::RAD_W-1:0]     rad_in,
	input  wire [hle_pkg::SQ_REM_W-1:0]  rem_in,
	input  wire [hle_pkg::ROOT_W-1:0]    root_in,
	input  wire [SIDE_W-1:0]             side_in,
	output logic                         v_out,
	output logic [hle_pkg::RAD_W-1:0]    rad_out,
	output logic [hle_pkg::SQ_REM_W-1:0] rem_out,
	output logic [hle_pkg::ROOT_W-1:0]   root_out,
	output logic [SIDE_W-1:0]            side_out
);
	import hle_pkg::*;

	localparam int T_W = SQ_REM_W + 2;

	logic [RAD_W-1:0]    rad_c;
	logic [SQ_REM_W-1:0] rem_c;
	logic [ROOT_W-1:0]   root_c;

	always_comb begin
		logic [T_W-1:0] t;
		logic [T_W-1:0] trial;
		logic           ge;
		rad_c  = rad_in;
		rem_c  = rem_in;
		root_c = root_in;
		for (int i = 0; i < STEPS; i++) begin
			t     = {rem_c, rad_c[RAD_W-1 -: 2]};
			trial = T_W'({root_c, 2'b01});
			ge    = (t >= trial);
			rem_c  = ge ? SQ_REM_W'(t - trial) : SQ_REM_W'(t);
			root_c = {root_c[ROOT_W-2:0], ge};
			rad_c  = rad_c << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_out  <= rad_c;
			rem_out  <= rem_c;
			root_out <= root_c;
			side_out <= side_in;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/hle_div_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A few quotient bits of restoring division, then one register stage.
module hle_div_stage #(
	parameter int DIV_W  = 24,
	parameter int BITS_W = 32,
	parameter int Q_W    = 32,
	parameter int STEPS  = 4,
	parameter int SIDE_W = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                en,
	input  wire                v_in,
	input  wire [BITS_W-1:0]   bits_in,
	input  wire [DIV_W-1:0]    rem_in,
	input  wire [Q_W-1:0]      quo_in,
	input  wire [DIV_W-1:0]    dvs_in,
	input  wire [SIDE_W-1:0]   side_in,
	output logic               v_out,
	output logic [BITS_W-1:0]  bits_out,
	output logic [DIV_W-1:0]   rem_out,
	output logic [Q_W-1:0]     quo_out,
	output logic [DIV_W-1:0]   dvs_out,
	output logic [SIDE_W-1:0]  side_out
);

	logic [BITS_W-1:0] bits_c;
	logic [DIV_W-1:0]  rem_c;
	logic [Q_W-1:0]    quo_c;

	always_comb begin
		logic [DIV_W:0] t;
		logic           ge;
		bits_c = bits_in;
		rem_c  = rem_in;
		quo_c  = quo_in;
		for (int i = 0; i < STEPS; i++) begin
			t     = {rem_c, bits_c[BITS_W-1]};
			ge    = (t >= {1'b0, dvs_in});
			rem_c = ge ? DIV_W'(t - {1'b0, dvs_in}) : DIV_W'(t);
			quo_c = {quo_c[Q_W-2:0], ge};
			bits_c = bits_c << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bits_out <= bits_c;
			rem_out  <= rem_c;
			quo_out  <= quo_c;
			dvs_out  <= dvs_in;
			side_out <= side_in;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import hle_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int DRAIN_CYCLES = 40;   // margin for the pipeline depth plus the output buffer

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [0:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	hle_in_if  residual();
	hle_out_if result();

	huber_loss_eval i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.residual (residual.sink),
		.result   (result.source),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Mirror of the two Huber registers, updated once both writes of a setting are issued.
	logic [CFG_W-1:0] cur_scale;
	logic [CFG_W-1:0] cur_thresh;

	logic [S_W-1:0] residual_backlog[$];  // beats not yet offered
	result_t        loss_expected[$];     // predictions awaiting their result beat

	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	bit in_taken;
	int n_errors;
	int n_checked;
	int n_outliers;
	int n_settings;

	// floor(sqrt(x)), digit by digit
	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] root;
		logic [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= root + b) begin
				x = x - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// Expected loss, first and second derivative for one squared residual
	function automatic result_t huber_predict(logic [S_W-1:0] s_in);
		result_t r;
		logic [63:0] s;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] root;
		logic [63:0] d1;
		logic [63:0] mag;
		s = 64'(s_in);
		a = 64'(cur_scale);
		b = 64'(cur_thresh);
		if (s > b) begin
			root = int_sqrt(s << 16);
			r.loss_value = VAL_W'(((64'd2 * a * root) >> 16) - b);
			d1 = (a << 16) / root;
			if (d1 > 64'hFFFF_FFFF)
				d1 = 64'hFFFF_FFFF;
			if (d1 == 0)
				d1 = 1;
			mag = (d1 << 31) / s;
			if (mag > 64'(SAT_NEG_MAG))
				mag = 64'(SAT_NEG_MAG);
			r.first_deriv = D1_W'(d1);
			r.second_deriv = D2_W'(64'd0 - mag);
			r.is_outlier = 1'b1;
		end else begin
			r.loss_value = VAL_W'(s);
			r.first_deriv = ONE_Q16;
			r.second_deriv = '0;
			r.is_outlier = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH beat %0d %s: got %h expected %h", n_checked, what, got, want);
		n_errors++;
	endtask

	// Residuals biased around the threshold, with extremes and wide random values
	function automatic logic [S_W-1:0] residual_pick(logic [CFG_W-1:0] thr);
		case ($urandom_range(7))
			0: return thr + S_W'($urandom_range(4)) - S_W'(2);
			1: return S_W'($urandom_range(255));
			2: return ~S_W'($urandom_range(255));
			3: return S_W'($urandom) >> $urandom_range(31);
			default: return S_W'($urandom);
		endcase
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Run limit: far above the slowest correct run
	initial begin
		#4ms;
		$display("timeout with %0d results outstanding", loss_expected.size());
		$display("huber_loss_eval verification failed");
		$finish;
	end

	// Sender: offer the next beat once the current one is taken (or none is up)
	always @(negedge clk) begin
		if (!residual.valid || in_taken) begin
			if (residual_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				residual.valid <= 1'b1;
				residual.squared_residual <= residual_backlog.pop_front();
			end else begin
				residual.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off while hold_cycles runs down
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result.ready <= 1'b0;
			hold_cycles--;
		end else begin
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Input beats: predict on acceptance
	always @(posedge clk) begin
		in_taken = residual.valid && residual.ready;
		if (in_taken)
			loss_expected.push_back(huber_predict(residual.squared_residual));
	end

	// Output beats: compare with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (result.valid && result.ready) begin
			if (loss_expected.size() == 0) begin
				report_mismatch("unexpected beat, loss", 64'(result.loss_value), 64'd0);
			end else begin
				want = loss_expected.pop_front();
				if (result.loss_value !== want.loss_value)
					report_mismatch("loss_value", 64'(result.loss_value), 64'(want.loss_value));
				if (result.first_deriv !== want.first_deriv)
					report_mismatch("first_deriv", 64'(result.first_deriv),
						64'(want.first_deriv));
				if (result.second_deriv !== want.second_deriv)
					report_mismatch("second_deriv", 64'(result.second_deriv),
						64'(want.second_deriv));
				if (result.is_outlier !== want.is_outlier)
					report_mismatch("is_outlier", 64'(result.is_outlier), 64'(want.is_outlier));
				if (want.is_outlier)
					n_outliers++;
				n_checked++;
			end
		end
	end

	// Wait until everything offered has come back, then let the pipe empty
	task automatic wait_quiet();
		while (residual_backlog.size() > 0 || residual.valid || loss_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Both registers written while the block is idle
	task automatic load_setting(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b);
		wait_quiet();
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_SCALE_A;
		wr_data <= a;
		@(negedge clk);
		wr_index <= REG_THRESHOLD_B;
		wr_data <= b;
		@(negedge clk);
		wr_en <= 1'b0;
		cur_scale = a;
		cur_thresh = b;
		n_settings++;
	endtask

	task automatic queue_random(int n);
		repeat (n) residual_backlog.push_back(residual_pick(cur_thresh));
	endtask

	initial begin
		logic [CFG_W-1:0] sa[8];
		logic [CFG_W-1:0] sb[8];
		logic [S_W-1:0] dir_reset[13];
		logic [S_W-1:0] dir_zero[5];
		logic [S_W-1:0] dir_huge[4];
		logic [15:0] root_a;
		int k;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_SCALE_A;
		wr_data = '0;
		residual.valid = 1'b0;
		residual.squared_residual = '0;
		result.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		in_taken = 1'b0;
		n_errors = 0;
		n_checked = 0;
		n_outliers = 0;
		n_settings = 0;
		cur_scale = CFG_RESET;
		cur_thresh = CFG_RESET;
		dir_reset = '{32'h0, 32'h1, 32'hFFFF, 32'h10000, 32'h10001, 32'h10002,
			32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h0001_0100, 32'h0100_0000};
		dir_zero = '{32'h0, 32'h1, 32'h2, 32'hFFFF_FFFF, 32'h0001_0000};
		dir_huge = '{32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, at reset values: zero, threshold edges, extremes, bit patterns
		foreach (dir_reset[i])
			residual_backlog.push_back(dir_reset[i]);
		// zero scale with zero threshold: every nonzero residual is an outlier at the clamp
		load_setting('0, '0);
		foreach (dir_zero[i])
			residual_backlog.push_back(dir_zero[i]);
		// huge scale, tiny residuals: first derivative saturation, second at its floor; plus the largest residual
		load_setting('1, '0);
		foreach (dir_huge[i])
			residual_backlog.push_back(dir_huge[i]);

		// Random settings, extremes first
		root_a = 16'($urandom);
		sa = '{CFG_RESET, '1, '0, 32'h1, 32'(root_a) << 8, CFG_W'($urandom), '1, '0};
		sb = '{CFG_RESET, '1, '1, 32'h1, (32'(root_a) * 32'(root_a)) >> 8,
			CFG_W'($urandom), '0, CFG_W'($urandom)};
		for (k = 0; k < 8; k++) begin
			load_setting(sa[k], sb[k]);
			send_idle_pct = (k % 4 == 1 || k % 4 == 3) ? ((k % 4 == 1) ? 87 : 13) : 0;
			recv_stall_pct = (k % 4 == 2) ? 87 : ((k % 4 == 3) ? 13 : 0);
			if (k == 4) begin
				// long receiver hold-off while the sender keeps pushing
				hold_cycles = 300;
				send_idle_pct = 0;
			end
			queue_random(240);
		end

		wait_quiet();
		$display("checked %0d result beats (%0d outliers) over %0d register settings",
			n_checked, n_outliers, n_settings);
		$display("idle patterns: none, sender gaps, receiver stalls, both, one long hold-off");
		if (n_errors == 0 && loss_expected.size() == 0) begin
			$display("huber_loss_eval verification clean");
		end else begin
			$display("huber_loss_eval verification failed");
		end
		$finish;
	end

endmodule
